// File: rtl/ath_pkg.sv
// ----------------------------------------------------------------------------
// ath_pkg
// Shared types and constants of the averaged heat/cool thermostat.
// ----------------------------------------------------------------------------
`default_nettype none

package ath_pkg;

    // field widths
    localparam int SAMPLE_W   = 10;
    localparam int LEVEL_W    = 9;
    localparam int TARGET_W   = 8;
    localparam int SUM_W      = 13;
    localparam int COUNT_W    = 4;
    localparam int BLINK_W    = 4;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ON   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_TEMP = 2'd1;
    localparam logic [TARGET_W-1:0]  TARGET_RESET    = 8'd60;

    // parameter defaults
    localparam int AVG_LENGTH_DEFAULT  = 10;
    localparam int START_LEVEL_DEFAULT = 35;

    // reciprocal divide: shift chosen so the quotient is exact for any
    // sum below 2**SUM_W and any divisor up to 16
    localparam int DIV_SHIFT = SUM_W + 4;
    localparam int DIV_M_W   = DIV_SHIFT + 1;
    localparam int PROD_W    = SUM_W + DIV_M_W;

    // control thresholds and blink period
    localparam logic [LEVEL_W-1:0] START_MARGIN = 9'd5;
    localparam logic [LEVEL_W-1:0] STOP_MARGIN  = 9'd1;
    localparam logic [BLINK_W-1:0] BLINK_PERIOD = 4'd10;

    typedef struct packed {
        logic heater;
        logic cooler;
        logic lamp;
    } ctrl_flags_t;

endpackage

`default_nettype wire

// File: rtl/ath_ifs.sv
// ----------------------------------------------------------------------------
// ath interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ath_sample_if;
    logic                         valid;
    logic                         ready;
    logic [ath_pkg::SAMPLE_W-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

interface ath_result_if;
    logic                        valid;
    logic                        ready;
    logic                        heat_drive;
    logic                        cool_drive;
    logic                        indicator_lit;
    logic [ath_pkg::LEVEL_W-1:0] average_level;

    modport source (output valid, output heat_drive, output cool_drive,
                    output indicator_lit, output average_level, input ready);
    modport sink   (input valid, input heat_drive, input cool_drive,
                    input indicator_lit, input average_level, output ready);
endinterface

interface ath_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ath_pkg::CFG_IDX_W-1:0]  index;
    logic [ath_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/ath_avg.sv
// ----------------------------------------------------------------------------
// ath_avg
// Running sum of halved samples and block mean by reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module ath_avg #(
    parameter int AVG_LENGTH  = ath_pkg::AVG_LENGTH_DEFAULT,
    parameter int START_LEVEL = ath_pkg::START_LEVEL_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         advance,
    input  wire logic [ath_pkg::SAMPLE_W-1:0] sample,
    output logic      [ath_pkg::LEVEL_W-1:0]  level_next
);

    localparam logic [ath_pkg::DIV_M_W-1:0] DIV_M = ath_pkg::DIV_M_W'(
        ((1 << ath_pkg::DIV_SHIFT) + AVG_LENGTH - 1) / AVG_LENGTH);
    localparam logic [ath_pkg::COUNT_W-1:0] LAST_COUNT = ath_pkg::COUNT_W'(AVG_LENGTH);

    logic [ath_pkg::SUM_W-1:0]   sum_reg,   sum_next;
    logic [ath_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [ath_pkg::LEVEL_W-1:0] level_reg;
    logic [ath_pkg::SUM_W-1:0]   sum_inc;
    logic [ath_pkg::COUNT_W-1:0] count_inc;
    logic [ath_pkg::PROD_W-1:0]  product;

    always_comb
    begin
        sum_inc   = sum_reg + ath_pkg::SUM_W'(sample[ath_pkg::SAMPLE_W-1:1]);
        count_inc = count_reg + 1'b1;
        product   = ath_pkg::PROD_W'(sum_inc) * ath_pkg::PROD_W'(DIV_M);
        if (count_inc == LAST_COUNT)
        begin
            level_next = product[ath_pkg::DIV_SHIFT +: ath_pkg::LEVEL_W];
            sum_next   = '0;
            count_next = '0;
        end
        else
        begin
            level_next = level_reg;
            sum_next   = sum_inc;
            count_next = count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            level_reg <= ath_pkg::LEVEL_W'(START_LEVEL);
        end
        else if (advance)
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
            level_reg <= level_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ath_ctrl.sv
// ----------------------------------------------------------------------------
// ath_ctrl
// Bang-bang heater/cooler control and heat indicator blinking.
// ----------------------------------------------------------------------------
`default_nettype none

module ath_ctrl (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         advance,
    input  wire logic                         enable,
    input  wire logic [ath_pkg::TARGET_W-1:0] target,
    input  wire logic [ath_pkg::LEVEL_W-1:0]  level,
    output ath_pkg::ctrl_flags_t              flags_next
);

    ath_pkg::ctrl_flags_t        flags_reg;
    logic [ath_pkg::BLINK_W-1:0] blink_reg, blink_next;
    logic                        phase_reg, phase_next;
    logic [ath_pkg::LEVEL_W-1:0] tgt;
    logic [ath_pkg::LEVEL_W-1:0] diff;
    logic                        above;
    logic                        below;
    logic [ath_pkg::BLINK_W-1:0] blink_tick;

    always_comb
    begin
        tgt        = ath_pkg::LEVEL_W'(target);
        above      = level > tgt;
        below      = tgt > level;
        diff       = above ? (level - tgt) : (tgt - level);
        flags_next = flags_reg;
        blink_next = blink_reg;
        phase_next = phase_reg;
        blink_tick = '0;
        if (enable)
        begin
            // first matching rule acts
            if (below && diff > ath_pkg::START_MARGIN && !flags_reg.heater
                && !flags_reg.cooler)
            begin
                flags_next.heater = 1'b1;
                blink_next        = '0;
            end
            else if (above && diff > ath_pkg::START_MARGIN && !flags_reg.heater
                     && !flags_reg.cooler)
            begin
                flags_next.cooler = 1'b1;
            end
            else if (above && diff > ath_pkg::STOP_MARGIN && flags_reg.heater)
            begin
                flags_next.heater = 1'b0;
            end
            else if (below && diff > ath_pkg::STOP_MARGIN && flags_reg.cooler)
            begin
                flags_next.cooler = 1'b0;
            end

            if (flags_next.heater)
            begin
                blink_tick = blink_next + 1'b1;
                blink_next = blink_tick;
                if (blink_tick >= ath_pkg::BLINK_PERIOD)
                begin
                    flags_next.lamp = !phase_reg;
                    phase_next      = !phase_reg;
                    blink_next      = '0;
                end
            end
            else
            begin
                flags_next.lamp = flags_next.cooler;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            blink_reg <= '0;
            phase_reg <= 1'b0;
        end
        else if (advance)
        begin
            flags_reg <= flags_next;
            blink_reg <= blink_next;
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/averaged_thermostat_heat_cool.sv
// ----------------------------------------------------------------------------
// averaged_thermostat_heat_cool
// Ten-sample averaging thermostat with heater, cooler and heat indicator.
// ----------------------------------------------------------------------------
// Usage:
//   sample : one ADC conversion per transaction (adc_sample).
//   result : one transaction per sample with heat_drive, cool_drive,
//            indicator_lit and average_level after that sample.
//   cfg    : register writes, always ready; index 0 is device_on,
//            index 1 is target_temp. Write only while no sample is in flight.
// Timing: a sample is taken into an input register; when the result register
//   is free or being taken, the average, control and indicator are computed
//   and loaded into the result register. One sample per cycle is sustained
//   while result is taken; the path is the sum add and the reciprocal multiply.
// Stall: when result is not taken, the result register holds, the input
//   register fills and sample.ready drops; nothing is lost.
// Reset: sum and count clear, average = START_LEVEL, actuators and LED off,
//   device_on = 0, target_temp = 60.
// ----------------------------------------------------------------------------
`default_nettype none

module averaged_thermostat_heat_cool #(
    parameter int AVG_LENGTH  = ath_pkg::AVG_LENGTH_DEFAULT,
    parameter int START_LEVEL = ath_pkg::START_LEVEL_DEFAULT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    ath_sample_if.sink    sample,
    ath_result_if.source  result,
    ath_cfg_if.sink       cfg
);

    logic                          s1_valid_reg;
    logic [ath_pkg::SAMPLE_W-1:0]  s1_sample_reg;
    logic                          out_valid_reg;
    ath_pkg::ctrl_flags_t          out_flags_reg;
    logic [ath_pkg::LEVEL_W-1:0]   out_level_reg;
    logic                          device_on_reg;
    logic [ath_pkg::TARGET_W-1:0]  target_reg;
    logic                          advance;
    logic                          take_sample;
    logic [ath_pkg::LEVEL_W-1:0]   level_next;
    ath_pkg::ctrl_flags_t          flags_next;

    assign advance     = s1_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !s1_valid_reg || advance;
    assign take_sample = sample.valid && sample.ready;
    assign cfg.ready   = 1'b1;

    assign result.valid         = out_valid_reg;
    assign result.heat_drive    = out_flags_reg.heater;
    assign result.cool_drive    = out_flags_reg.cooler;
    assign result.indicator_lit = out_flags_reg.lamp;
    assign result.average_level = out_level_reg;

    ath_avg #(
        .AVG_LENGTH  (AVG_LENGTH),
        .START_LEVEL (START_LEVEL)
    ) u_avg (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .sample     (s1_sample_reg),
        .level_next (level_next)
    );

    ath_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .enable     (device_on_reg),
        .target     (target_reg),
        .level      (level_next),
        .flags_next (flags_next)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_on_reg <= 1'b0;
            target_reg    <= ath_pkg::TARGET_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                ath_pkg::REG_DEVICE_ON:   device_on_reg <= cfg.data[0];
                ath_pkg::REG_TARGET_TEMP: target_reg    <= cfg.data;
                default:                  ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            s1_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_sample)
        begin
            s1_sample_reg <= sample.adc_sample;
        end
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_flags_reg <= flags_next;
            out_level_reg <= level_next;
        end
    end

    // heater and cooler are exclusive
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.heat_drive && result.cool_drive))
        else $error("heater and cooler both on");

    // without heating the LED follows the cooler
    a_lamp: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.heat_drive) |-> (result.indicator_lit == result.cool_drive))
        else $error("indicator inconsistent with actuators");

    // a held input stage accepts no new sample
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |-> !take_sample)
        else $error("sample accepted into a full input stage");

    // a sample that advances from the input stage reaches the result register in the next cycle
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced item missing from result register");

endmodule

`default_nettype wire

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// Averaged thermostat testbench
// Drives ADC samples and register writes into the heat/cool thermostat and
// checks every result against a cycle-free model of the averaging, the
// bang-bang control and the indicator blink. Both channels idle at random,
// and the setpoint and enable are changed between phases once all results
// have arrived.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AVG_LEN     = ath_pkg::AVG_LENGTH_DEFAULT;
    localparam int START_LVL   = ath_pkg::START_LEVEL_DEFAULT;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int PHASES      = 10;
    localparam int GROUPS      = 11;
    localparam int IDLE_PCT    = 31;

    // indexes with no register behind them
    localparam logic [ath_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [ath_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        logic                        heater;
        logic                        cooler;
        logic                        lamp;
        logic [ath_pkg::LEVEL_W-1:0] level;
    } reading_t;

    class thermo_scoreboard;
        bit                           enabled;
        logic [ath_pkg::TARGET_W-1:0] target;
        logic [ath_pkg::SUM_W-1:0]    sum;
        logic [ath_pkg::COUNT_W-1:0]  count;
        logic [ath_pkg::LEVEL_W-1:0]  mean;
        bit                           heating;
        bit                           cooling;
        bit                           lamp;
        bit                           phase;
        logic [ath_pkg::BLINK_W-1:0]  blink_count;
        reading_t                     expected_q[$];
        int                           failures;
        int                           checked;
        int                           heat_starts;
        int                           cool_starts;
        int                           blink_flips;

        function new();
            enabled     = 1'b0;
            target      = ath_pkg::TARGET_RESET;
            sum         = '0;
            count       = '0;
            mean        = ath_pkg::LEVEL_W'(START_LVL);
            heating     = 1'b0;
            cooling     = 1'b0;
            lamp        = 1'b0;
            phase       = 1'b0;
            blink_count = '0;
            failures    = 0;
            checked     = 0;
            heat_starts = 0;
            cool_starts = 0;
            blink_flips = 0;
        endfunction

        function void write_register(logic [ath_pkg::CFG_IDX_W-1:0] idx,
                                     logic [ath_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                ath_pkg::REG_DEVICE_ON:   enabled = data[0];
                ath_pkg::REG_TARGET_TEMP: target  = data;
                default: ;
            endcase
        endfunction

        function void regulate();
            int avg;
            int tgt;
            int diff;
            bit above;
            bit below;
            avg   = int'(mean);
            tgt   = int'(target);
            above = avg > tgt;
            below = tgt > avg;
            diff  = above ? avg - tgt : tgt - avg;
            if (below && diff > int'(ath_pkg::START_MARGIN) && !heating && !cooling) begin
                heating     = 1'b1;
                blink_count = '0;
                heat_starts++;
            end else if (above && diff > int'(ath_pkg::START_MARGIN) && !heating
                         && !cooling) begin
                cooling = 1'b1;
                cool_starts++;
            end else if (above && diff > int'(ath_pkg::STOP_MARGIN) && heating) begin
                heating = 1'b0;
            end else if (below && diff > int'(ath_pkg::STOP_MARGIN) && cooling) begin
                cooling = 1'b0;
            end

            if (heating) begin
                blink_count = blink_count + 1'b1;
                if (blink_count >= ath_pkg::BLINK_PERIOD) begin
                    lamp        = ~phase;
                    phase       = lamp;
                    blink_count = '0;
                    blink_flips++;
                end
            end else begin
                lamp = cooling;
            end
        endfunction

        function void note_sample(logic [ath_pkg::SAMPLE_W-1:0] value);
            sum   = sum + ath_pkg::SUM_W'(value >> 1);
            count = count + 1'b1;
            if (count >= AVG_LEN) begin
                mean  = ath_pkg::LEVEL_W'(sum / AVG_LEN);
                sum   = '0;
                count = '0;
            end
            if (enabled)
                regulate();
            expected_q.push_back('{heater: heating, cooler: cooling, lamp: lamp,
                                   level: mean});
        endfunction

        function void report(string what, reading_t want, reading_t got);
            failures++;
            if (failures <= 10)
                $display({"[%0t] %s: expected heat=%b cool=%b lamp=%b avg=%0d,",
                          " got heat=%b cool=%b lamp=%b avg=%0d"},
                         $realtime, what, want.heater, want.cooler, want.lamp, want.level,
                         got.heater, got.cooler, got.lamp, got.level);
        endfunction

        function void check_result(reading_t got);
            reading_t want;
            if (expected_q.size() == 0) begin
                report("result with no sample behind it", got, got);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.heater !== want.heater || got.cooler !== want.cooler ||
                got.lamp !== want.lamp || got.level !== want.level)
                report("result mismatch", want, got);
        endfunction

        function void flush_leftover();
            while (expected_q.size() != 0)
                report("result never arrived", expected_q.pop_front(), '0);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   no_idle;
    int   cycle_count;
    int   reg_writes;
    logic [ath_pkg::TARGET_W-1:0] cur_target;

    ath_sample_if sample_ch ();
    ath_result_if result_ch ();
    ath_cfg_if    cfg_ch ();

    thermo_scoreboard thermo = new();

    averaged_thermostat_heat_cool i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // observe every transaction on the edge it happens
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
                thermo.check_result('{heater: result_ch.heat_drive,
                                      cooler: result_ch.cool_drive,
                                      lamp: result_ch.indicator_lit,
                                      level: result_ch.average_level});
            if (cfg_ch.valid && cfg_ch.ready)
                thermo.write_register(cfg_ch.index, cfg_ch.data);
            if (sample_ch.valid && sample_ch.ready)
                thermo.note_sample(sample_ch.adc_sample);
        end
    end

    always @(negedge clk)
    begin
        result_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // enter and leave at a falling edge
    task automatic send_sample(input logic [ath_pkg::SAMPLE_W-1:0] value);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid      <= 1'b1;
        sample_ch.adc_sample <= value;
        do @(posedge clk); while (!sample_ch.ready);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [ath_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [ath_pkg::CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
        reg_writes++;
    endtask

    // hold the sender until every outstanding result is back
    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        @(negedge clk);
        while (thermo.pending() != 0)
            @(negedge clk);
    endtask

    function automatic logic [ath_pkg::SAMPLE_W-1:0] sample_near(input int level);
        int v;
        v = 2 * level + int'($urandom_range(1));
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return ath_pkg::SAMPLE_W'(v);
    endfunction

    task automatic run_group();
        int level;
        if ($urandom_range(99) < 20)
        begin
            repeat (AVG_LEN) send_sample(ath_pkg::SAMPLE_W'($urandom_range(1023)));
        end
        else
        begin
            level = int'(cur_target) + int'($urandom_range(24)) - 12;
            repeat (AVG_LEN) send_sample(sample_near(level + int'($urandom_range(2)) - 1));
        end
    endtask

    initial
    begin
        logic on;
        rst_n                = 1'b0;
        no_idle              = 1'b0;
        cycle_count          = 0;
        reg_writes           = 0;
        cur_target           = ath_pkg::TARGET_RESET;
        sample_ch.valid      = 1'b0;
        sample_ch.adc_sample = '0;
        result_ch.ready      = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = ath_pkg::REG_DEVICE_ON;
        cfg_ch.data          = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // disabled: averaging runs, outputs hold at reset
        send_sample(10'd0);
        send_sample(10'd1023);
        send_sample(10'd1);
        send_sample(10'd1022);
        wait_drained();
        // start average far below the setpoint: heater starts at once; the high block average stops it
        write_reg(ath_pkg::REG_DEVICE_ON, 8'h01);
        repeat (6) send_sample(10'd1023);
        // the cooler then starts on the high average
        repeat (2) send_sample(10'd1023);
        // the next block average is still above the setpoint, so the cooler stays on
        repeat (10) send_sample(10'd0);
        repeat (3) send_sample(10'd0);
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            case (p)
                0:       cur_target = '0;
                1:       cur_target = '1;
                default: cur_target = ath_pkg::TARGET_W'($urandom_range(255));
            endcase
            write_reg(ath_pkg::REG_TARGET_TEMP, cur_target);
            on = (p == 6) ? 1'b0 : ($urandom_range(9) != 0);
            write_reg(ath_pkg::REG_DEVICE_ON, {7'($urandom_range(127)), on});
            if (p == 3)
                write_reg(REG_SPARE_A, 8'($urandom_range(255)));
            if (p == 7)
                write_reg(REG_SPARE_B, 8'($urandom_range(255)));
            no_idle = (p == 4);
            for (int g = 0; g < GROUPS; g++)
                run_group();
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (10) @(posedge clk);
        thermo.flush_leftover();

        $display("Checked %0d results over %0d register writes and %0d setpoint phases",
                 thermo.checked, reg_writes, PHASES);
        $display("Heater started %0d times, cooler %0d times, indicator blinked %0d times",
                 thermo.heat_starts, thermo.cool_starts, thermo.blink_flips);
        if (thermo.failures == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
